[design/anel_pkg.sv]
// Shared constants, types and helpers of the alpha noise edge limiter.
package anel_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int FRAC = 24;
   localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;
   localparam int RECIP_W = 49 - PIXEL_BITS;

   localparam logic [PIXEL_BITS-1:0] PIX_MAX_V = PIXEL_BITS'(PIX_MAX);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'((64'd1 << 48) / PIX_MAX);
   localparam logic signed [27:0] Q_ONE = 28'(64'd1 << FRAC);

   localparam int ST_IN = 0;
   localparam int ST_RCP = 1;
   localparam int ST_CHK = 2;
   localparam int ST_VAL = 3;
   localparam int ST_SEL = 4;
   localparam int ST_OPS = 5;
   localparam int ST_DIV = 6;
   localparam int DIV_STEPS = FRAC + 1;
   localparam int ST_M1 = ST_DIV + DIV_STEPS;
   localparam int ST_M2 = ST_M1 + 1;
   localparam int ST_M3 = ST_M2 + 1;
   localparam int ST_OUT = ST_M3 + 1;
   localparam int NSTAGE = ST_OUT + 1;

   typedef enum logic [2:0] {
      CSR_LOW_STRENGTH  = 3'd0,
      CSR_HIGH_STRENGTH = 3'd1,
      CSR_CENTER_LEVEL  = 3'd2,
      CSR_ADJUST_MODE   = 3'd3,
      CSR_NOISE_SPAN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SHIFT_ALL   = 2'd0,
      MODE_SHIFT_ENDS  = 2'd1,
      MODE_SHRINK_ALL  = 2'd2,
      MODE_SHRINK_ENDS = 2'd3
   } mode_type;

   typedef struct packed {
      logic [16:0] low_strength;
      logic [16:0] high_strength;
      logic [16:0] center_level;
      mode_type    adjust_mode;
      logic [16:0] noise_span;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      low_strength:  17'd0,
      high_strength: 17'd0,
      center_level:  17'd32768,
      adjust_mode:   MODE_SHIFT_ALL,
      noise_span:    17'd0
   };

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pix;
      logic signed [24:0]    noise;
      logic [49:0]           wide;
      logic [24:0]           val;
      logic                  lo;
      logic                  hi;
      logic                  act;
      logic signed [27:0]    pt;
      logic [24:0]           num;
      logic [24:0]           den;
      logic [25:0]           rem;
      logic [24:0]           quo;
      logic signed [27:0]    lin;
      logic [25:0]           m1;
      logic signed [27:0]    shift;
      logic signed [27:0]    nz;
      logic signed [27:0]    pa;
      logic signed [27:0]    pb;
      logic [PIXEL_BITS-1:0] code;
   } stage_type;

   // Fixed-point product scaled back by 2^FRAC, rounded toward zero.
   function automatic logic signed [39:0] q24_trunc(input logic signed [63:0] prod);
      logic signed [63:0] sh;
      sh = prod >>> FRAC;
      if (prod < 0 && prod[FRAC-1:0] != '0) begin
         sh = sh + 64'sd1;
      end
      return sh[39:0];
   endfunction

endpackage

[design/alpha_noise_edge_limiter.sv]
// Top level of the alpha noise edge limiter: config registers and the datapath pipeline.
// Throughput is one beat per cycle while rsp_ready stays high; the 25-stage restoring divider sets the depth.
// Each stage holds when the stage after it is full and stalled, so bubbles are squeezed out.
// Synchronous reset clears all stage valid bits and restores the configuration registers.
// No request or configuration beat is taken while reset is high.
module alpha_noise_edge_limiter
   import anel_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_pixel_in,
   input  logic signed [16:0] req_noise_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_pixel_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_data
);

   cfg_type cfg_ff, cfg_in;
   stage_type pipe_ff [NSTAGE];
   stage_type pipe_in [NSTAGE];
   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] stage_rdy;

   function automatic stage_type stage_step(input int unsigned idx, input stage_type s,
                                            input cfg_type c);
      stage_type n;
      logic signed [27:0] vs, cen, ran, half, ira, rpos, diff, dens, opa, opb, m1s, r;
      logic [24:0] eff;
      logic [48:0] rcp_prod;
      logic [49:0] big, resid;
      logic [25:0] r2;
      logic signed [55:0] sprod, sprod_b;
      logic signed [29:0] xs;
      logic cond, mode01, qbit;
      n = s;
      vs = 28'(s.val);
      cen = 28'({c.center_level, 8'h00});
      ran = 28'({c.noise_span, 8'h00});
      half = 28'({c.noise_span, 7'h00});
      ira = Q_ONE - ran;
      rpos = Q_ONE - half;
      eff = s.lo ? {c.low_strength, 8'h00} : {c.high_strength, 8'h00};
      mode01 = (c.adjust_mode == MODE_SHIFT_ALL) || (c.adjust_mode == MODE_SHIFT_ENDS);
      m1s = 28'(s.m1);
      cond = 1'b0;
      if (idx == ST_RCP) begin
         rcp_prod = s.pix * RECIP_V;
         n.val = rcp_prod[48:24];
      end else if (idx == ST_CHK) begin
         big = s.val * PIX_MAX_V;
         n.wide = big;
      end else if (idx == ST_VAL) begin
         big = 50'({s.pix, 24'h000000});
         resid = big - s.wide;
         if (resid >= 50'(PIX_MAX_V)) begin
            n.val = s.val + 25'd1;
         end
      end else if (idx == ST_SEL) begin
         n.lo = (c.low_strength != '0) && (vs < cen);
         n.hi = (c.high_strength != '0) && (cen < vs);
         case (c.adjust_mode)
            MODE_SHIFT_ENDS: begin
               if (n.lo) begin
                  cond = vs < ran;
                  n.pt = (cen < ran) ? cen : ran;
               end else begin
                  cond = ira < vs;
                  n.pt = (cen < ira) ? ira : cen;
               end
            end
            MODE_SHRINK_ENDS: begin
               if (n.lo) begin
                  cond = vs < half;
                  n.pt = (cen < half) ? cen : half;
               end else begin
                  cond = rpos < vs;
                  n.pt = (cen < rpos) ? rpos : cen;
               end
            end
            default: begin
               cond = 1'b1;
               n.pt = cen;
            end
         endcase
         n.act = (n.lo || n.hi) && cond;
      end else if (idx == ST_OPS) begin
         diff = s.lo ? s.pt - vs : vs - s.pt;
         dens = s.lo ? s.pt : Q_ONE - s.pt;
         n.lin = s.lo ? (diff >>> 1) : -(diff >>> 1);
         if (s.act) begin
            n.num = diff[24:0];
            n.den = dens[24:0];
         end else begin
            n.num = '0;
            n.den = 25'd1;
         end
      end else if (idx >= ST_DIV && idx < ST_M1) begin
         r2 = (idx == ST_DIV) ? {1'b0, s.num} : {s.rem[24:0], 1'b0};
         qbit = r2 >= {1'b0, s.den};
         n.rem = qbit ? r2 - {1'b0, s.den} : r2;
         n.quo = {((idx == ST_DIV) ? 24'h000000 : s.quo[23:0]), qbit};
      end else if (idx == ST_M1) begin
         big = s.quo * ((c.adjust_mode == MODE_SHIFT_ALL) ? {1'b0, half[23:0]} : eff);
         n.m1 = big[49:24];
      end else if (idx == ST_M2) begin
         case (c.adjust_mode)
            MODE_SHIFT_ALL:  opa = s.hi ? -m1s : m1s;
            MODE_SHIFT_ENDS: opa = s.lin;
            default:         opa = 28'(s.noise);
         endcase
         opb = mode01 ? 28'(eff) : Q_ONE - m1s;
         sprod = opa * opb;
         r = 28'(q24_trunc(64'(sprod)));
         n.shift = (s.act && mode01) ? r : '0;
         n.nz = (s.act && !mode01 && s.m1 != '0) ? r : 28'(s.noise);
      end else if (idx == ST_M3) begin
         sprod = s.shift * vs;
         sprod_b = s.nz * vs;
         n.pa = 28'(q24_trunc(64'(sprod)));
         n.pb = 28'(q24_trunc(64'(sprod_b)));
      end else if (idx == ST_OUT) begin
         xs = 30'(vs) + 30'(s.pa) + 30'(s.pb);
         if (c.noise_span == '0) begin
            n.code = s.pix;
         end else if (xs < 0) begin
            n.code = '0;
         end else if (xs >= 30'(Q_ONE)) begin
            n.code = PIX_MAX_V;
         end else begin
            n.code = xs[FRAC-1 -: PIXEL_BITS];
         end
      end
      return n;
   endfunction

   assign csr_ready = !reset;
   assign req_ready = stage_rdy[0] && !reset;
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign rsp_pixel_out = 16'(pipe_ff[NSTAGE-1].code);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_STRENGTH:  cfg_in.low_strength = csr_data;
            CSR_HIGH_STRENGTH: cfg_in.high_strength = csr_data;
            CSR_CENTER_LEVEL:  cfg_in.center_level = csr_data;
            CSR_ADJUST_MODE:   cfg_in.adjust_mode = mode_type'(csr_data[1:0]);
            CSR_NOISE_SPAN:    cfg_in.noise_span = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      stage_rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         stage_rdy[i] = !vld_ff[i] || stage_rdy[i+1];
      end
   end

   always_comb begin
      pipe_in[0] = '0;
      pipe_in[0].pix = req_pixel_in[PIXEL_BITS-1:0];
      pipe_in[0].noise = {req_noise_in, 8'h00};
      vld_in[0] = req_valid && !reset;
      for (int i = 1; i < NSTAGE; i++) begin
         pipe_in[i] = stage_step(i, pipe_ff[i-1], cfg_ff);
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         vld_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         for (int i = 0; i < NSTAGE; i++) begin
            if (stage_rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (stage_rdy[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

endmodule

[design/anel_checker.sv]
// Port-level assertions for the alpha noise edge limiter, bound to the top level.
module anel_checker
   import anel_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_pixel_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("Stalled response beat changed or dropped.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Request stalled although the response side is free.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, NSTAGE))
      else $error("Response beat appeared without a matching request beat.");

endmodule

bind alpha_noise_edge_limiter anel_checker u_anel_checker (.*);

[dv/alpha_noise_edge_limiter_tb.sv]
// Self-checking testbench of the alpha noise edge limiter with a built-in fixed-point predictor.
module alpha_noise_edge_limiter_tb;
   import anel_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE = 64'sd1 << 24;
   localparam longint SATV = 64'sd1 << 40;
   localparam longint CODE_MAX = (64'sd1 << 16) - 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] pixel;
      logic [16:0] noise;
   } pixel_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_pixel_in = '0;
   logic signed [16:0] req_noise_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_LOW_STRENGTH;
   logic [16:0] csr_data = '0;

   pixel_beat_type pending_pixels[$];
   logic [15:0] expected_pixels[$];
   logic [16:0] low_str, high_str, center, span;
   mode_type mode;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   alpha_noise_edge_limiter dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sat40(input longint a);
      if (a > SATV) return SATV;
      if (a < -SATV) return -SATV;
      return a;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      longint ma, mb;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      if (ma != 0 && mb > ((64'sd1 << 62) / ma)) return ((a < 0) != (b < 0)) ? -SATV : SATV;
      return sat40((a * b) / ONE);
   endfunction

   function automatic longint qdiv(input longint a, input longint b);
      longint lim;
      lim = 64'sd1 << 38;
      if (b == 0) return 0;
      a = sat40(a);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      return sat40((a * ONE) / b);
   endfunction

   function automatic logic [15:0] limited_pixel(input pixel_beat_type b);
      longint v, c, r, h, nz, sh, x, eff, t, lim, ira, rpos;
      sh = 0;
      if (span == 0) return b.pixel;
      v = (longint'(b.pixel) * ONE) / CODE_MAX;
      c = longint'(center) * 256;
      r = longint'(span) * 256;
      h = r / 2;
      nz = longint'($signed(b.noise)) * 256;
      if (low_str != 0 && v < c) begin
         eff = longint'(low_str) * 256;
         case (mode)
            MODE_SHIFT_ALL: sh = qmul(qmul(qdiv(c - v, c), h), eff);
            MODE_SHIFT_ENDS: begin
               if (v < r) begin
                  lim = c < r ? c : r;
                  sh = qmul((lim - v) / 2, eff);
               end
            end
            MODE_SHRINK_ALL: begin
               t = qmul(qdiv(c - v, c), eff);
               if (t > 0) nz = qmul(nz, ONE - t);
            end
            default: begin
               if (v < h) begin
                  lim = c < h ? c : h;
                  t = qmul(qdiv(lim - v, lim), eff);
                  if (t > 0) nz = qmul(nz, ONE - t);
               end
            end
         endcase
      end
      if (high_str != 0 && c < v) begin
         eff = longint'(high_str) * 256;
         case (mode)
            MODE_SHIFT_ALL: sh = qmul(qmul(qdiv(c - v, ONE - c), h), eff);
            MODE_SHIFT_ENDS: begin
               ira = ONE - r;
               if (ira < v) begin
                  lim = c < ira ? ira : c;
                  sh = qmul((lim - v) / 2, eff);
               end
            end
            MODE_SHRINK_ALL: begin
               t = qmul(qdiv(v - c, ONE - c), eff);
               if (t > 0) nz = qmul(nz, ONE - t);
            end
            default: begin
               rpos = ONE - h;
               if (rpos < v) begin
                  lim = c < rpos ? rpos : c;
                  t = qmul(qdiv(v - lim, ONE - lim), eff);
                  if (t > 0) nz = qmul(nz, ONE - t);
               end
            end
         endcase
      end
      x = v + qmul(sh, v);
      x += qmul(nz, v);
      if (x < 0) x = 0;
      if (x > ONE) x = ONE;
      x = (x << 16) >>> 24;
      if (x > CODE_MAX) x = CODE_MAX;
      return x[15:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%s", msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(limited_pixel({req_pixel_in, req_noise_in}));
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               {req_pixel_in, req_noise_in} <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("mismatch: unexpected beat %0d", rsp_pixel_out));
         end else begin
            if (rsp_pixel_out !== expected_pixels[0]) begin
               report_mismatch($sformatf("mismatch: pixel_out %0d, expected %0d",
                                         rsp_pixel_out, expected_pixels[0]));
            end
            void'(expected_pixels.pop_front());
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LOW_STRENGTH: low_str = data;
         CSR_HIGH_STRENGTH: high_str = data;
         CSR_CENTER_LEVEL: center = data;
         CSR_ADJUST_MODE: mode = mode_type'(data[1:0]);
         default: span = data;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0) begin
         @(negedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [16:0] pick_level();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'h1FFFF;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   function automatic pixel_beat_type random_beat();
      pixel_beat_type b;
      b.pixel = $urandom_range(9) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0) : 16'($urandom);
      case ($urandom_range(7))
         0: b.noise = 17'h10000;
         1: b.noise = 17'd32768;
         2: b.noise = 17'($urandom);
         default: b.noise = 17'($signed(17'($urandom_range(65536))) - 17'sd32768);
      endcase
      return b;
   endfunction

   initial begin
      low_str = 0;
      high_str = 0;
      center = 17'd32768;
      mode = MODE_SHIFT_ALL;
      span = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 16; i++) begin
         pending_pixels.push_back({16'(1 << i), 17'd32768});
      end
      drain();
      for (int m = 0; m < 4; m++) begin
         write_reg(CSR_LOW_STRENGTH, 17'd65536);
         write_reg(CSR_HIGH_STRENGTH, m == 3 ? 17'h1FFFF : 17'd65536);
         write_reg(CSR_ADJUST_MODE, 17'(m));
         write_reg(CSR_NOISE_SPAN, 17'd65536);
         pending_pixels.push_back({16'h0000, 17'h10000});
         pending_pixels.push_back({16'hFFFF, 17'd32768});
         pending_pixels.push_back({16'h8000, 17'h1FFFF});
         pending_pixels.push_back({16'h0100, 17'h0FFFF});
         pending_pixels.push_back({16'hFF00, 17'h10000});
         drain();
      end
      for (int phase = 0; phase < 25; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 45; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 45; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         write_reg(CSR_LOW_STRENGTH, pick_level());
         write_reg(CSR_HIGH_STRENGTH, pick_level());
         write_reg(CSR_CENTER_LEVEL, pick_level());
         write_reg(CSR_ADJUST_MODE, 17'($urandom_range(3)));
         write_reg(CSR_NOISE_SPAN, $urandom_range(7) == 0 ? 17'd0 : pick_level());
         repeat (48) pending_pixels.push_back(random_beat());
         drain();
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
